### rtl/core/speech_end_detector_macros.svh
// Assertion macros shared by the speech end detector RTL.
`ifndef SPEECH_END_DETECTOR_MACROS_SVH
`define SPEECH_END_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define SED_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define SED_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sed_pkg.sv
// Types and constants of the speech end detector.
`timescale 1ns / 1ps

package sed_pkg;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned Channels = 8;

  localparam logic [7:0]  DefaultMask = 8'h0F;
  localparam logic [16:0] PctScale    = 17'd100;
  localparam logic [4:0]  DivSteps    = 5'd17;
  localparam logic        VadStatus   = 1'b0;

  localparam logic [9:0]  WindowReset = 10'd60;
  localparam logic [9:0]  IgnoreReset = 10'd60;
  localparam logic [6:0]  BreakReset  = 7'd30;
  localparam logic [15:0] MaxReset    = 16'd1000;

  typedef enum logic [1:0] {
    CFG_WINDOW = 2'd0,
    CFG_IGNORE = 2'd1,
    CFG_BREAK  = 2'd2,
    CFG_MAX    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IGNORE = 2'd1,
    MODE_BREAK  = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_CMP  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

endpackage

### rtl/core/speech_end_detector.sv
// Speech end detector: session, window and activity tracking with a serial percent divide.
`timescale 1ns / 1ps

// One input transfer is one 10 ms frame. A frame that closes no window is
// taken with only the counter update. A frame that closes an ignore or break
// window runs the activity percentage through a restoring divider that
// resolves one quotient bit per cycle, so the block stays busy through the
// counter update, 17 divide steps and the threshold decision. A frame that
// raises an end event also moves the event into the output register, and
// waits there while an earlier event is still not taken; the next frame may
// arrive while an event sits in the output register. There is no clearing
// pass after reset. Configuration writes are taken in any cycle and are
// meant to be issued while no frame is in flight.
module speech_end_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // [0] has_vad, [8:1] vad_mask, [9] has_wake, [12:10] wake_channel,
  // [13] wake_first, [15:14] zero
  input  logic [sed_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] vad_status, [7:1] zero
  output logic [sed_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [sed_pkg::CfgDataW-1:0]   cfg_data_i
);

  import sed_pkg::*;

  `include "speech_end_detector_macros.svh"

  // Configuration registers
  logic [9:0]  window_frames_q;
  logic [9:0]  ignore_frames_q;
  logic [6:0]  break_percent_q;
  logic [15:0] max_frames_q;

  // Detector state
  state_e      state_q, state_d;
  mode_e       mode_q, mode_d;
  logic [2:0]  sel_q, sel_d;
  logic [9:0]  ac_q, ac_d;
  logic [9:0]  wc_q, wc_d;
  logic [15:0] sc_q, sc_d;
  logic [4:0]  step_q, step_d;
  logic        m_valid_q, m_valid_d;

  // Divider datapath
  logic [16:0] dq_q, dq_d;
  logic [9:0]  rem_q, rem_d;

  // Frame fields
  logic       f_has_vad, f_has_wake, f_first;
  logic [7:0] f_mask_raw, f_mask;
  logic [2:0] f_chan;
  logic       s_acc, m_acc;

  assign f_has_vad  = s_axis_tdata[0];
  assign f_mask_raw = s_axis_tdata[8:1];
  assign f_has_wake = s_axis_tdata[9];
  assign f_chan     = s_axis_tdata[12:10];
  assign f_first    = s_axis_tdata[13];
  assign f_mask     = f_has_vad ? f_mask_raw : DefaultMask;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_acc         = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW-1){1'b0}}, VadStatus};
  assign cfg_ready_o   = 1'b1;

  // Frame update values
  logic        drop;
  mode_e       mode_n;
  logic [9:0]  ac_b, wc_b, ac_n, wc_n;
  logic [15:0] sc_b, sc_n;
  logic        chan_hit;
  logic [16:0] dividend;

  // One restoring divide step
  logic [10:0] r_shift, r_diff;
  logic        r_borrow;
  logic [16:0] pct;

  always_comb begin
    drop   = f_has_wake && !f_first;
    sel_d  = f_has_wake ? f_chan : sel_q;
    mode_n = (f_has_wake && f_first) ? MODE_IGNORE : mode_q;
    ac_b   = (f_has_wake && f_first) ? 10'd0 : ac_q;
    wc_b   = (f_has_wake && f_first) ? 10'd0 : wc_q;
    sc_b   = (f_has_wake && f_first) ? 16'd0 : sc_q;
    chan_hit = (32'(sel_d) < Channels) && f_mask[sel_d];
    wc_n   = wc_b + 10'd1;
    sc_n   = sc_b + 16'd1;
    ac_n   = chan_hit ? ac_b + 10'd1 : ac_b;
    dividend = 17'(ac_n) * PctScale;

    r_shift  = {rem_q, dq_q[16]};
    r_diff   = r_shift - {1'b0, wc_q};
    r_borrow = (r_shift < {1'b0, wc_q});
    pct      = (wc_q == 10'd0) ? 17'd0 : dq_q;
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    ac_d      = ac_q;
    wc_d      = wc_q;
    sc_d      = sc_q;
    step_d    = step_q;
    dq_d      = dq_q;
    rem_d     = rem_q;
    m_valid_d = m_valid_q && !m_acc;

    unique case (state_q)
      S_IDLE: begin
        if (s_acc && !drop) begin
          mode_d = mode_n;
          ac_d   = ac_b;
          wc_d   = wc_b;
          sc_d   = sc_b;
          if (mode_n != MODE_IDLE) begin
            ac_d = ac_n;
            wc_d = wc_n;
            sc_d = sc_n;
            priority if (sc_n >= max_frames_q) begin
              mode_d  = MODE_IDLE;
              state_d = S_EMIT;
            end else if ((mode_n == MODE_IGNORE && wc_n >= ignore_frames_q) ||
                         (mode_n == MODE_BREAK && wc_n >= window_frames_q)) begin
              // Load the divider with active*100 over the window length
              dq_d    = dividend;
              rem_d   = 10'd0;
              step_d  = 5'd0;
              state_d = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        rem_d  = r_borrow ? r_shift[9:0] : r_diff[9:0];
        dq_d   = {dq_q[15:0], !r_borrow};
        step_d = step_q + 5'd1;
        if (step_q == DivSteps - 5'd1) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        ac_d    = 10'd0;
        wc_d    = 10'd0;
        state_d = S_IDLE;
        if (mode_q == MODE_IGNORE) begin
          if (pct > {10'd0, break_percent_q}) begin
            mode_d = MODE_BREAK;
          end
        end else if (pct < {10'd0, break_percent_q}) begin
          mode_d  = MODE_IDLE;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold the event until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_frames_q <= WindowReset;
      ignore_frames_q <= IgnoreReset;
      break_percent_q <= BreakReset;
      max_frames_q    <= MaxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WINDOW: window_frames_q <= cfg_data_i[9:0];
        CFG_IGNORE: ignore_frames_q <= cfg_data_i[9:0];
        CFG_BREAK:  break_percent_q <= cfg_data_i[6:0];
        CFG_MAX:    max_frames_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= MODE_IDLE;
      sel_q     <= 3'd0;
      ac_q      <= 10'd0;
      wc_q      <= 10'd0;
      sc_q      <= 16'd0;
      step_q    <= 5'd0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      if (s_acc) begin
        sel_q <= sel_d;
      end
      ac_q      <= ac_d;
      wc_q      <= wc_d;
      sc_q      <= sc_d;
      step_q    <= step_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
  end

  `SED_ASSERT_IMP(a_step_bound, state_q == S_DIV, step_q < DivSteps, "divide step overrun")
  `SED_ASSERT_IMP(a_cmp_after_div, state_q == S_CMP, $past(state_q) == S_DIV,
                  "decision without divide")
  `SED_ASSERT_IMP(a_active_le_window, 1'b1, ac_q <= wc_q, "active count above window count")
  `SED_ASSERT_IMP(a_emit_disarmed, state_q == S_EMIT, mode_q == MODE_IDLE,
                  "end event while armed")
  `SED_ASSERT_IMP(a_rem_below_div, state_q == S_DIV && wc_q != 10'd0, rem_q < wc_q,
                  "remainder not below divisor")

endmodule

### tb/speech_end_detector_test.sv
// Self-checking testbench for the speech end detector: frames in, end events checked.
`timescale 1ns / 1ps

module speech_end_detector_test;
  import sed_pkg::*;

  localparam int unsigned DrainSettle  = 24;    // longest frame: update, 17 divide steps, decide, emit
  localparam int unsigned EndSettle    = 40;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned RandomFrames = 1600;
  localparam int unsigned PhaseFrames  = 160;

  typedef struct packed {
    logic       wake_first;
    logic [2:0] wake_channel;
    logic       has_wake;
    logic [7:0] vad_mask;
    logic       has_vad;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Detector state as predicted from the accepted frames.
  mode_e       det_mode = MODE_IDLE;
  logic [2:0]  sel_channel = '0;
  logic [9:0]  active_cnt = '0;
  logic [9:0]  window_cnt = '0;
  logic [15:0] session_cnt = '0;
  logic [9:0]  lim_window = WindowReset;
  logic [9:0]  lim_ignore = IgnoreReset;
  logic [6:0]  lim_break = BreakReset;
  logic [15:0] lim_max = MaxReset;

  logic        end_events[$];  // vad_status of each end event still to arrive

  int unsigned frames_sent = 0;
  int unsigned frames_armed = 0;
  int unsigned ends_predicted = 0;
  int unsigned ends_checked = 0;
  int unsigned settings_tried = 0;
  int unsigned mismatches = 0;

  logic        steady = 1'b0;   // no idling on either side
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  speech_end_detector DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 100) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // Advance the predicted detector by one frame; return 1 on an end event.
  function automatic bit advance_detector(frame_t f);
    logic [7:0]  mask;
    int unsigned pct;
    bit          ended;
    mask = f.has_vad ? f.vad_mask : DefaultMask;
    ended = 1'b0;
    if (f.has_wake) begin
      sel_channel = f.wake_channel;
      if (!f.wake_first) return 1'b0;
      det_mode = MODE_IGNORE;
      active_cnt = '0;
      window_cnt = '0;
      session_cnt = '0;
    end
    if (det_mode == MODE_IDLE) return 1'b0;
    frames_armed++;
    window_cnt = window_cnt + 10'd1;
    session_cnt = session_cnt + 16'd1;
    if (sel_channel < Channels && mask[sel_channel]) active_cnt = active_cnt + 10'd1;
    pct = (window_cnt == 0) ? 0 : (int'(active_cnt) * 100) / int'(window_cnt);
    if (session_cnt >= lim_max) begin
      ended = 1'b1;
      det_mode = MODE_IDLE;
    end else if (det_mode == MODE_IGNORE) begin
      if (window_cnt >= lim_ignore) begin
        if (pct > lim_break) det_mode = MODE_BREAK;
        active_cnt = '0;
        window_cnt = '0;
      end
    end else if (det_mode == MODE_BREAK) begin
      if (window_cnt >= lim_window) begin
        if (pct < lim_break) begin
          ended = 1'b1;
          det_mode = MODE_IDLE;
        end
        active_cnt = '0;
        window_cnt = '0;
      end
    end
    return ended;
  endfunction

  function automatic frame_t make_frame(logic has_vad, logic [7:0] mask, logic has_wake,
                                        logic [2:0] ch, logic first);
    frame_t f;
    f.has_vad = has_vad;
    f.vad_mask = mask;
    f.has_wake = has_wake;
    f.wake_channel = ch;
    f.wake_first = first;
    return f;
  endfunction

  function automatic frame_t noise_frame();
    return make_frame(1'($urandom_range(1)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 3'($urandom_range(7)),
                      1'($urandom_range(1)));
  endfunction

  // A plain frame whose vad_mask bit for channel ch is given; other bits are random.
  function automatic frame_t speech_frame(logic [2:0] ch, logic talking);
    frame_t f;
    f = make_frame($urandom_range(99) < 85, 8'($urandom_range(255)), 1'b0,
                   3'($urandom_range(7)), 1'($urandom_range(1)));
    f.vad_mask[ch] = talking;
    return f;
  endfunction

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_frame(frame_t f);
    if (!steady && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tdata <= {{(InDataW - $bits(frame_t)){1'b0}}, f};
    s_axis_tvalid <= 1'b1;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    frames_sent++;
    if (advance_detector(f)) begin
      end_events.push_back(VadStatus);
      ends_predicted++;
    end
  endtask

  // Stop offering frames, wait for every end event, then let the divider settle.
  task automatic wait_drained(int unsigned settle);
    s_axis_tvalid <= 1'b0;
    while (end_events.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, int unsigned value);
    cfg_index_i <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    cfg_valid_i <= 1'b1;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WINDOW: lim_window = value[9:0];
      CFG_IGNORE: lim_ignore = value[9:0];
      CFG_BREAK:  lim_break = value[6:0];
      CFG_MAX:    lim_max = value[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_limits(int unsigned window, int unsigned ignore, int unsigned brk,
                             int unsigned max);
    write_register(CFG_WINDOW, window);
    write_register(CFG_IGNORE, ignore);
    write_register(CFG_BREAK, brk);
    write_register(CFG_MAX, max);
    settings_tried++;
  endtask

  function automatic int unsigned pick_window();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 14) return 1023;
    if (r < 20) return 1;
    return $urandom_range(2, 12);
  endfunction

  function automatic int unsigned pick_break();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 18) return 127;
    if (r < 24) return 100;
    return $urandom_range(10, 90);
  endfunction

  function automatic int unsigned pick_max();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 14) return 65535;
    if (r < 20) return 1;
    return $urandom_range(15, 90);
  endfunction

  // First wake, a talking stretch, then a quiet stretch, with some noise mixed in.
  task automatic run_session(int unsigned len);
    logic [2:0]  ch;
    int unsigned p_talk;
    int unsigned p_quiet;
    int unsigned turn;
    frame_t      f;
    ch = 3'($urandom_range(7));
    p_talk = $urandom_range(60, 100);
    p_quiet = $urandom_range(0, 35);
    turn = $urandom_range(len);
    f = speech_frame(ch, 1'($urandom_range(1)));
    f.has_wake = 1'b1;
    f.wake_channel = ch;
    f.wake_first = 1'b1;
    send_frame(f);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 10) f = noise_frame();
      else f = speech_frame(ch, $urandom_range(99) < ((i < turn) ? p_talk : p_quiet));
      send_frame(f);
    end
  endtask

  // Reset limits of 60/60/30/1000: one full session through both phases.
  task automatic test_default_limits();
    run_session(150);
    wait_drained(DrainSettle);
  endtask

  task automatic test_wake_rules();
    load_limits(2, 2, 50, 1000);
    send_frame(make_frame(1'b1, 8'hFF, 1'b0, 3'd0, 1'b0));  // idle: ignored
    send_frame(make_frame(1'b1, 8'hFF, 1'b1, 3'd5, 1'b0));  // repeat wake: dropped
    send_frame(make_frame(1'b0, 8'h00, 1'b1, 3'd3, 1'b1));  // default mask, channel 3 active
    send_frame(make_frame(1'b1, 8'h08, 1'b0, 3'd0, 1'b0));  // full ignore window: to break
    send_frame(make_frame(1'b1, 8'h00, 1'b0, 3'd0, 1'b0));
    send_frame(make_frame(1'b1, 8'h00, 1'b0, 3'd0, 1'b0));  // quiet break window ends
    send_frame(make_frame(1'b1, 8'hFF, 1'b1, 3'd0, 1'b0));
    send_frame(make_frame(1'b0, 8'hFF, 1'b1, 3'd7, 1'b1));  // default mask: channel 7 quiet
    send_frame(make_frame(1'b1, 8'h80, 1'b0, 3'd0, 1'b0));  // exactly at threshold: stay
    send_frame(make_frame(1'b1, 8'h80, 1'b0, 3'd0, 1'b0));
    send_frame(make_frame(1'b1, 8'h80, 1'b0, 3'd0, 1'b0));
    send_frame(make_frame(1'b1, 8'h7F, 1'b1, 3'd2, 1'b0));  // repeat wake moves channel
    send_frame(make_frame(1'b1, 8'h04, 1'b0, 3'd0, 1'b0));
    send_frame(make_frame(1'b1, 8'h00, 1'b0, 3'd0, 1'b0));  // at threshold in break: no end
    send_frame(make_frame(1'b1, 8'hFF, 1'b1, 3'd7, 1'b1));  // rearm restarts counters
    send_frame(make_frame(1'b1, 8'h00, 1'b0, 3'd0, 1'b0));
    wait_drained(DrainSettle);
  endtask

  task automatic test_limit_extremes();
    load_limits(0, 0, 0, 0);
    send_frame(make_frame(1'b1, 8'hFF, 1'b1, 3'd7, 1'b1));  // zero session limit ends at once
    send_frame(make_frame(1'b1, 8'hFF, 1'b0, 3'd7, 1'b0));
    wait_drained(DrainSettle);
    load_limits(0, 0, 0, 3);
    send_frame(make_frame(1'b1, 8'h02, 1'b1, 3'd1, 1'b1));  // one-frame windows
    send_frame(make_frame(1'b1, 8'h00, 1'b0, 3'd0, 1'b0));
    send_frame(make_frame(1'b1, 8'hFD, 1'b0, 3'd0, 1'b0));
    wait_drained(DrainSettle);
    load_limits(1, 1, 127, 4);
    send_frame(make_frame(1'b1, 8'hFF, 1'b1, 3'd0, 1'b1));  // unreachable threshold: max ends
    for (int i = 0; i < 3; i++) send_frame(make_frame(1'b1, 8'hFF, 1'b0, 3'd0, 1'b0));
    wait_drained(DrainSettle);
  endtask

  task automatic test_random_sessions();
    int unsigned phase;
    int unsigned start;
    phase = 0;
    while (frames_sent < RandomFrames) begin
      load_limits(pick_window(), pick_window(), pick_break(), pick_max());
      steady <= (phase == 2);
      start = frames_sent;
      while (frames_sent - start < PhaseFrames) begin
        repeat ($urandom_range(2)) send_frame(noise_frame());
        run_session($urandom_range(4, 70));
      end
      wait_drained(DrainSettle);
      phase++;
    end
    steady <= 1'b0;
  endtask

  // Hold the receiver off while every frame ends a session, so the block backs up.
  task automatic test_output_stall();
    load_limits(5, 5, 30, 1);
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 40; i++) begin
      send_frame(make_frame(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b1,
                            3'($urandom_range(7)), 1'b1));
    end
    wait_drained(DrainSettle);
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      m_axis_tready <= 1'b0;
      hold_left <= HoldCycles - 1;
      hold_served <= hold_served + 1;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 12);
    end
  end

  // Outputs are stable at the falling edge; a transfer takes place at the next rising one.
  always @(negedge clk_i) begin : check_end_events
    logic want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (end_events.size() == 0) begin
        report_mismatch("end event with none predicted");
      end else begin
        want = end_events.pop_front();
        ends_checked++;
        if (m_axis_tdata[0] !== want)
          report_mismatch($sformatf("vad_status %b, want %b", m_axis_tdata[0], want));
        if (m_axis_tdata[OutDataW-1:1] !== '0)
          report_mismatch($sformatf("padding bits %h not zero", m_axis_tdata[OutDataW-1:1]));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_limits();
    test_wake_rules();
    test_limit_extremes();
    test_random_sessions();
    test_output_stall();
    wait_drained(EndSettle);
    $display("Sent %0d frames (%0d counted while armed) under %0d limit settings;",
             frames_sent, frames_armed, settings_tried);
    $display("checked %0d end events, including a long output stall.", ends_checked);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
